@@ hdl/sida_pkg.sv @@
// shared constants and types for the signed integer to decimal text converter
package sida_pkg;

  // width of the input port and the number of its bits that are converted
  localparam int IN_WIDTH    = 64;
  localparam int VALUE_WIDTH = 64;

  // decimal digits needed for a magnitude of up to 2^(VALUE_WIDTH-1)
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int REM_W = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] MINUS_CHAR = 8'd45;

  // per-cycle command shared by every digit cell
  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ hdl/sida_cell.sv @@
// one bcd digit cell: add-3 correction and shift for binary to decimal, digit shift for output
module sida_cell (
  input  logic                  clk,
  input  sida_pkg::cell_ctrl_t  ctrl,
  input  logic                  carry_in,
  input  logic [3:0]            digit_in,
  output logic                  carry_out,
  output logic [3:0]            digit
);

  logic [3:0] digit_r;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  end

  assign carry_out = adj[3];
  assign digit     = digit_r;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit_r <= 4'd0;
    end else if (ctrl.dabble) begin
      digit_r <= {adj[2:0], carry_in};
    end else if (ctrl.shift) begin
      digit_r <= digit_in;
    end
  end

endmodule

@@ hdl/signed_int_to_decimal_ascii.sv @@
// Signed integer to decimal ASCII text converter.
// Input channel (in_valid/in_ready/in_value): one two's-complement integer per
// transaction; the low VALUE_WIDTH bits are used.
// Output channel (out_valid/out_ready/out_character/out_last): the decimal text,
// most significant character first, '-' ahead of a negative value, out_last on
// the final character. Zero gives "0"; the most negative value converts exactly.
// One number is worked on at a time. After a transaction is taken the magnitude
// is shifted into a row of NUM_DIGITS bcd cells, one bit per cycle, then
// leading zero digits are shifted out of the top cell, one per cycle, then one
// character leaves per cycle while the receiver is ready. Most of the time per
// number goes to the bit-serial pass through the cell row. The output register
// lets the next number be taken while the last character still waits. A stalled
// receiver freezes the character stream and, while characters are being sent,
// the cells. Synchronous reset empties the output register and returns to idle;
// there is no clearing pass.
module signed_int_to_decimal_ascii (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [sida_pkg::IN_WIDTH-1:0]  in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_character,
  output logic                           out_last
);

  localparam int VW = sida_pkg::VALUE_WIDTH;
  localparam int ND = sida_pkg::NUM_DIGITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_EMIT
  } state_t;

  state_t                      state_r;
  logic [VW-1:0]               mag_r;
  logic                        sign_pend_r;
  logic [sida_pkg::CNT_W-1:0]  cnt_r;
  logic [sida_pkg::REM_W-1:0]  remain_r;
  logic                        out_valid_r;
  logic [7:0]                  out_character_r;
  logic                        out_last_r;

  logic [VW-1:0]               raw;
  logic                        neg;
  logic [VW-1:0]               mag;
  logic                        in_fire;
  logic                        slot_free;
  logic                        out_load;
  logic                        more_digits;
  logic [3:0]                  top_digit;
  sida_pkg::cell_ctrl_t        ctrl;

  logic [3:0]                  digits [ND];
  logic                        carries [ND];

  assign raw         = in_value[VW-1:0];
  assign neg         = raw[VW-1];
  assign mag         = neg ? (~raw + {{(VW-1){1'b0}}, 1'b1}) : raw;
  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign slot_free   = !out_valid_r || out_ready;
  assign out_load    = (state_r == S_EMIT) && slot_free;
  assign top_digit   = digits[ND-1];
  assign more_digits = (remain_r != sida_pkg::REM_W'(1));

  always_comb begin
    ctrl.clear  = in_fire;
    ctrl.dabble = (state_r == S_CONV);
    ctrl.shift  = ((state_r == S_SKIP) && (top_digit == 4'd0) && more_digits) ||
                  ((state_r == S_EMIT) && slot_free && !sign_pend_r);
  end

  // row of digit cells, least significant at index 0
  for (genvar i = 0; i < ND; i++) begin : g_cell
    if (i == 0) begin : g_first
      sida_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (mag_r[VW-1]),
        .digit_in  (4'd0),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end else begin : g_rest
      sida_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carries[i-1]),
        .digit_in  (digits[i-1]),
        .carry_out (carries[i]),
        .digit     (digits[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            mag_r       <= mag;
            sign_pend_r <= neg;
            cnt_r       <= '0;
            state_r     <= S_CONV;
          end
        end
        S_CONV: begin
          mag_r <= {mag_r[VW-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == sida_pkg::CNT_W'(VW - 1)) begin
            remain_r <= sida_pkg::REM_W'(ND);
            state_r  <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zeros, keep at least one digit
          if ((top_digit == 4'd0) && more_digits) begin
            remain_r <= remain_r - 1'b1;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (sign_pend_r) begin
              out_character_r <= sida_pkg::MINUS_CHAR;
              out_last_r      <= 1'b0;
              sign_pend_r     <= 1'b0;
            end else begin
              out_character_r <= sida_pkg::DIGIT_BASE + {4'd0, top_digit};
              out_last_r      <= !more_digits;
              remain_r        <= remain_r - 1'b1;
              if (!more_digits) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

`ifndef NO_ASSERTIONS
  // a character still waiting when a new number is taken must close the previous one
  a_pending_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (!out_valid || out_last))
    else $error("new number taken while a non-final character was pending");

  // only a minus sign or a decimal digit is ever presented
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_character == sida_pkg::MINUS_CHAR) ||
                   ((out_character >= 8'd48) && (out_character <= 8'd57))))
    else $error("illegal output character");

  // the sign is never the final character
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_character == sida_pkg::MINUS_CHAR)) |-> !out_last)
    else $error("minus sign marked last");

  // cells never get two commands at once
  a_ctrl_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.clear, ctrl.dabble, ctrl.shift}))
    else $error("conflicting cell commands");
`endif

endmodule

@@ test/sida_text_checker.sv @@
// checker that predicts and compares the decimal text of every converted number
`timescale 1ns / 100ps

module sida_text_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [sida_pkg::IN_WIDTH-1:0]  in_value,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     out_character,
  input  logic                           out_last,
  output int                             fail_count,
  output int                             pending_chars,
  output int                             numbers_seen,
  output int                             negatives_seen,
  output int                             chars_seen
);

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  text_char_t expected_text[$];

  initial begin
    fail_count     = 0;
    numbers_seen   = 0;
    negatives_seen = 0;
    chars_seen     = 0;
  end

  assign pending_chars = expected_text.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s, got %0d, expected %0d (character %0d)",
             $realtime, what, got, want, chars_seen);
    fail_count++;
  endtask

  // text of one number, most significant character first
  function automatic void predict_decimal_text(input logic [sida_pkg::IN_WIDTH-1:0] value);
    logic [63:0] mask;
    logic [63:0] raw;
    logic [63:0] magnitude;
    logic        negative;
    logic [3:0]  digits[$];
    mask      = {64{1'b1}} >> (64 - sida_pkg::VALUE_WIDTH);
    raw       = 64'(value) & mask;
    negative  = raw[sida_pkg::VALUE_WIDTH-1];
    // unsigned magnitude so the most negative value converts exactly
    magnitude = negative ? ((~raw + 64'd1) & mask) : raw;
    do begin
      digits.push_back(4'(magnitude % 64'd10));
      magnitude = magnitude / 64'd10;
    end while (magnitude != 0);
    if (negative) begin
      expected_text.push_back('{character: sida_pkg::MINUS_CHAR, last: 1'b0});
      negatives_seen++;
    end
    for (int i = digits.size() - 1; i >= 0; i--) begin
      expected_text.push_back('{character: sida_pkg::DIGIT_BASE + 8'(digits[i]),
                                last: (i == 0)});
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_decimal_text(in_value);
        numbers_seen++;
      end
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          report_mismatch("character with nothing expected", out_character, 0);
        end else begin
          text_char_t want;
          want = expected_text.pop_front();
          if (out_character !== want.character)
            report_mismatch("character", out_character, want.character);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
        chars_seen++;
      end
    end
  end

endmodule

@@ test/signed_int_to_decimal_ascii_tb.sv @@
// testbench top: drives numbers into the converter and gives the verdict
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_tb;

  localparam int RANDOM_ITEMS = 156;
  localparam int IDLE_LIMIT   = 3000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [sida_pkg::IN_WIDTH-1:0] in_value;
  logic                          out_valid;
  logic                          out_ready;
  logic [7:0]                    out_character;
  logic                          out_last;

  int fail_count;
  int pending_chars;
  int numbers_seen;
  int negatives_seen;
  int chars_seen;

  logic steady;
  int   ready_hold;
  int   idle_cycles;

  signed_int_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

  sida_text_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last       (out_last),
    .fail_count     (fail_count),
    .pending_chars  (pending_chars),
    .numbers_seen   (numbers_seen),
    .negatives_seen (negatives_seen),
    .chars_seen     (chars_seen)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mostly short pauses, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver stalls, switched off during steady stretches
  always @(negedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_hold = idle_length() - 1;
    end else begin
      out_ready <= 1'b1;
      ready_hold = $urandom_range(0, 15);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // starts and ends at a falling edge
  task automatic send_number(input logic [sida_pkg::IN_WIDTH-1:0] value);
    int gap;
    gap = (steady || $urandom_range(0, 1)) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // magnitudes spread over every digit count, plus raw bit patterns
  function automatic logic [63:0] random_number();
    logic [63:0] low;
    logic [63:0] high;
    logic [63:0] raw;
    longint      near_zero;
    int          num_digits;
    int          pick;
    raw  = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 3) return raw;
    if (pick == 3) begin
      near_zero = $urandom_range(0, 20);
      return near_zero - 10;
    end
    num_digits = $urandom_range(1, 19);
    low = 64'd1;
    repeat (num_digits - 1) low = low * 64'd10;
    high = (num_digits == 19) ? 64'h7FFF_FFFF_FFFF_FFFF : low * 64'd10 - 64'd1;
    if (num_digits == 1) low = 64'd0;
    raw = low + raw % (high - low + 64'd1);
    return $urandom_range(0, 1) ? -raw : raw;
  endfunction

  logic [63:0] directed_numbers[] = '{
    64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100, -64'sd999,
    64'd1000, -64'sd5, 64'd4294967296, -64'sd2147483648, 64'd12345678901234567,
    64'd999999999999999999, -64'sd999999999999999999,
    64'd1000000000000000000, -64'sd1000000000000000000,
    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
    64'hFFFF_FFFF_0000_0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
  };

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_value    = '0;
    out_ready   = 1'b0;
    steady      = 1'b0;
    ready_hold  = 0;
    idle_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_numbers[i]) send_number(directed_numbers[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // every so often run a stretch with neither side idling
      if (n % 30 == 0) steady = (n % 60 == 30);
      send_number(random_number());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending_chars != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("converted %0d numbers (%0d negative) into %0d characters",
             numbers_seen, negatives_seen, chars_seen);
    $display("covered zero, both range ends, every digit count and receiver stalls");
    if (fail_count == 0 && pending_chars == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
